### src/tis_pkg.sv
// shared types, constants and register codes for the thresholded image statistics block
`default_nettype none
package tis_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int MAX_PIXELS = 16777216;
    localparam int MAX_WIDTH  = 4096;

    localparam int PIX_W   = 16;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 24;
    localparam int LCOL_W  = 13;
    localparam int LROW_W  = 25;
    localparam int CNT_W   = 25;
    localparam int SUM_W   = 41;
    localparam int SQ_W    = 55;
    localparam int MAG_W   = 40;
    localparam int RW_W    = 13;
    localparam int ALU_W   = 96;
    localparam int DEN_W   = 50;
    localparam int QUO_W   = 48;
    localparam int MEAN_W  = 24;
    localparam int STD_W   = 23;

    // register indexes on the configuration port
    localparam logic [2:0] REG_LO_EN   = 3'd0;
    localparam logic [2:0] REG_HI_EN   = 3'd1;
    localparam logic [2:0] REG_TH_LOW  = 3'd2;
    localparam logic [2:0] REG_TH_HIGH = 3'd3;
    localparam logic [2:0] REG_ROW_W   = 3'd4;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel;
        logic                    is_null;
        logic                    last;
    } t_in;

    typedef struct packed {
        logic signed [39:0]       total;
        logic signed [MEAN_W-1:0] mean_q8;
        logic [STD_W-1:0]         std_q8;
        logic [CNT_W-1:0]         count;
        logic signed [PIX_W-1:0]  min_value;
        logic signed [PIX_W-1:0]  max_value;
        logic [LCOL_W-1:0]        min_col;
        logic [LROW_W-1:0]        min_row;
        logic [LCOL_W-1:0]        max_col;
        logic [LROW_W-1:0]        max_row;
    } t_out;

    typedef struct packed {
        logic                    lo_enable;
        logic                    hi_enable;
        logic signed [PIX_W-1:0] thresh_low;
        logic signed [PIX_W-1:0] thresh_high;
        logic [RW_W-1:0]         row_width;
    } t_cfg;

    // image totals handed from the accumulator to the finishing sequencer
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
        logic [CNT_W-1:0]        count;
        logic signed [PIX_W-1:0] min_value;
        logic signed [PIX_W-1:0] max_value;
        logic [LCOL_W-1:0]       min_col;
        logic [LROW_W-1:0]       min_row;
        logic [LCOL_W-1:0]       max_col;
        logic [LROW_W-1:0]       max_row;
    } t_snap;

endpackage
`default_nettype wire

### src/tis_accum.sv
// per-pixel accumulator: threshold test, sums, count, extremes and raster position
`default_nettype none
module tis_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tis_pkg::t_cfg  i_cfg,
    input  tis_pkg::t_in   i_pix,
    input  logic           i_accept,
    output logic           o_start,
    output tis_pkg::t_snap o_snap
);
    import tis_pkg::*;

    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [SQ_W-1:0]         r_sumsq, n_sumsq;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [PIX_W-1:0] r_min, n_min, r_max, n_max;
    logic [LCOL_W-1:0]       r_min_col, n_min_col, r_max_col, n_max_col;
    logic [LROW_W-1:0]       r_min_row, n_min_row, r_max_row, n_max_row;
    logic [COL_W-1:0]        r_col, n_col;
    logic [ROW_W-1:0]        r_row, n_row;

    logic signed [PIX_W-1:0] px;
    logic signed [31:0]      sq;
    logic [RW_W-1:0]         w;
    logic [LCOL_W-1:0]       col1;
    logic [LROW_W-1:0]       row1;
    logic                    inc;

    // pixel value and its square
    assign px = PIX_W'(signed'(i_pix.pixel[PIXEL_BITS-1:0]));
    assign sq = px * px;

    // effective row width and 1-based position
    always_comb begin
        if (i_cfg.row_width == '0) begin
            w = RW_W'(1);
        end else if (i_cfg.row_width > RW_W'(MAX_WIDTH)) begin
            w = RW_W'(MAX_WIDTH);
        end else begin
            w = i_cfg.row_width;
        end
    end
    assign col1 = {1'b0, r_col} + LCOL_W'(1);
    assign row1 = {1'b0, r_row} + LROW_W'(1);

    // inclusion test
    assign inc = !i_pix.is_null
               && !(i_cfg.lo_enable && (px < i_cfg.thresh_low))
               && !(i_cfg.hi_enable && (px > i_cfg.thresh_high))
               && (r_count < CNT_W'(MAX_PIXELS));

    // next values
    always_comb begin
        n_sum = r_sum;  n_sumsq = r_sumsq;  n_count = r_count;
        n_min = r_min;  n_max = r_max;
        n_min_col = r_min_col;  n_min_row = r_min_row;
        n_max_col = r_max_col;  n_max_row = r_max_row;
        n_col = r_col;  n_row = r_row;
        if (inc) begin
            if ((r_count == '0) || (px < r_min)) begin
                n_min = px;  n_min_col = col1;  n_min_row = row1;
            end
            if ((r_count == '0) || (px > r_max)) begin
                n_max = px;  n_max_col = col1;  n_max_row = row1;
            end
            n_sum   = r_sum + SUM_W'(px);
            n_sumsq = r_sumsq + SQ_W'($unsigned(sq));
            n_count = r_count + CNT_W'(1);
        end
        if (col1 >= w) begin
            n_col = '0;
            if (r_row < ROW_W'(MAX_PIXELS - 1)) begin
                n_row = r_row + ROW_W'(1);
            end
        end else begin
            n_col = col1[COL_W-1:0];
        end
    end

    // totals including the last pixel go straight to the sequencer
    assign o_start = i_accept && i_pix.last;
    always_comb begin
        o_snap.sum       = n_sum;
        o_snap.sumsq     = n_sumsq;
        o_snap.count     = n_count;
        o_snap.min_value = n_min;
        o_snap.max_value = n_max;
        o_snap.min_col   = n_min_col;
        o_snap.min_row   = n_min_row;
        o_snap.max_col   = n_max_col;
        o_snap.max_row   = n_max_row;
    end

    // state registers, cleared after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_start) begin
            r_sum <= '0;  r_sumsq <= '0;  r_count <= '0;
            r_min <= '0;  r_max <= '0;
            r_min_col <= LCOL_W'(1);  r_min_row <= LROW_W'(1);
            r_max_col <= LCOL_W'(1);  r_max_row <= LROW_W'(1);
            r_col <= '0;  r_row <= '0;
        end else if (i_accept) begin
            r_sum <= n_sum;  r_sumsq <= n_sumsq;  r_count <= n_count;
            r_min <= n_min;  r_max <= n_max;
            r_min_col <= n_min_col;  r_min_row <= n_min_row;
            r_max_col <= n_max_col;  r_max_row <= n_max_row;
            r_col <= n_col;  r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

### src/tis_calc.sv
// finishing sequencer: mean, variance and root on one shared add/subtract unit
`default_nettype none
module tis_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tis_pkg::t_snap i_snap,
    output logic           o_idle,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tis_pkg::t_out  o_out_data
);
    import tis_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MDIV  = 3'd1;
    localparam logic [2:0] S_MUL_A = 3'd2;
    localparam logic [2:0] S_MUL_B = 3'd3;
    localparam logic [2:0] S_MUL_C = 3'd4;
    localparam logic [2:0] S_VDIV  = 3'd5;
    localparam logic [2:0] S_SQRT  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [6:0]          r_cnt, n_cnt;
    t_snap               r_snap, n_snap;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic [ALU_W-1:0]    r_acc, n_acc, r_mcand, n_mcand, r_div, n_div;
    logic [MAG_W-1:0]    r_mplier, n_mplier;
    logic [DEN_W-1:0]    r_rem, n_rem, r_den, n_den;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [MEAN_W-1:0]   r_mean, n_mean;
    logic [STD_W-1:0]    r_sd, n_sd;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic [ALU_W-1:0]    alu_a, alu_b;
    logic                alu_sub;
    logic [ALU_W:0]      alu_y;
    logic                alu_ge;
    logic [DEN_W-1:0]    rem2;
    logic [SUM_W-1:0]    sabs;
    logic [QUO_W-1:0]    div_quo;
    logic [DEN_W-1:0]    div_rem;
    logic [ALU_W-1:0]    mul_acc, sq_res, sq_v;

    // operand select for the shared unit
    assign rem2 = {r_rem[DEN_W-2:0], r_div[ALU_W-1]};
    always_comb begin
        case (r_state)
            S_MDIV, S_VDIV: begin
                alu_a = ALU_W'(rem2);  alu_b = ALU_W'(r_den);  alu_sub = 1'b1;
            end
            S_MUL_A, S_MUL_C: begin
                alu_a = r_acc;  alu_b = r_mcand;  alu_sub = 1'b0;
            end
            S_MUL_B: begin
                alu_a = r_acc;  alu_b = r_mcand;  alu_sub = 1'b1;
            end
            S_SQRT: begin
                alu_a = r_acc;  alu_b = r_mcand | ALU_W'(r_den);  alu_sub = 1'b1;
            end
            default: begin
                alu_a = '0;  alu_b = '0;  alu_sub = 1'b0;
            end
        endcase
    end

    // shared add/subtract, carry out means no borrow
    assign alu_y  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (ALU_W+1)'(alu_sub);
    assign alu_ge = alu_y[ALU_W];

    // per-step results
    assign div_quo = {r_quo[QUO_W-2:0], alu_ge};
    assign div_rem = alu_ge ? alu_y[DEN_W-1:0] : rem2;
    assign mul_acc = r_mplier[0] ? alu_y[ALU_W-1:0] : r_acc;
    assign sq_res  = alu_ge ? ((r_mcand >> 1) | ALU_W'(r_den)) : (r_mcand >> 1);
    assign sq_v    = alu_ge ? alu_y[ALU_W-1:0] : r_acc;
    assign sabs    = i_snap.sum[SUM_W-1] ? SUM_W'(-i_snap.sum) : SUM_W'(i_snap.sum);

    // sequencer
    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;  n_snap = r_snap;  n_mag = r_mag;
        n_acc = r_acc;  n_mcand = r_mcand;  n_div = r_div;  n_mplier = r_mplier;
        n_rem = r_rem;  n_den = r_den;  n_quo = r_quo;
        n_mean = r_mean;  n_sd = r_sd;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_snap = i_snap;
                    n_mag  = sabs[MAG_W-1:0];
                    n_mean = '0;
                    n_sd   = '0;
                    if (i_snap.count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_div   = {sabs[MAG_W-1:0], 8'd0, QUO_W'(0)};
                        n_rem   = '0;
                        n_quo   = '0;
                        n_den   = DEN_W'(i_snap.count);
                        n_cnt   = 7'(QUO_W - 1);
                        n_state = S_MDIV;
                    end
                end
            end
            S_MDIV, S_VDIV: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_div = r_div << 1;
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == '0) begin
                    if (r_state == S_MDIV) begin
                        n_mean   = r_snap.sum[SUM_W-1] ? MEAN_W'(-div_quo) : MEAN_W'(div_quo);
                        n_acc    = '0;
                        n_mcand  = ALU_W'(r_snap.sumsq);
                        n_mplier = MAG_W'(r_snap.count);
                        n_cnt    = 7'(CNT_W - 1);
                        n_state  = S_MUL_A;
                    end else begin
                        n_acc   = ALU_W'(div_quo);
                        n_mcand = '0;
                        n_den   = DEN_W'(1) << (QUO_W - 2);
                        n_cnt   = 7'(QUO_W / 2 - 1);
                        n_state = S_SQRT;
                    end
                end
            end
            S_MUL_A, S_MUL_B, S_MUL_C: begin
                n_acc    = mul_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 7'd1;
                if (r_cnt == '0) begin
                    case (r_state)
                        S_MUL_A: begin
                            n_mcand  = ALU_W'(r_mag);
                            n_mplier = r_mag;
                            n_cnt    = 7'(MAG_W - 1);
                            n_state  = S_MUL_B;
                        end
                        S_MUL_B: begin
                            // spread of the sums, scaled by 2^16 for the Q8 root
                            n_div    = mul_acc << 16;
                            n_acc    = '0;
                            n_mcand  = ALU_W'(r_snap.count);
                            n_mplier = MAG_W'(r_snap.count);
                            n_cnt    = 7'(CNT_W - 1);
                            n_state  = S_MUL_C;
                        end
                        default: begin
                            n_den   = mul_acc[DEN_W-1:0];
                            n_rem   = '0;
                            n_quo   = '0;
                            n_cnt   = 7'(ALU_W - 1);
                            n_state = S_VDIV;
                        end
                    endcase
                end
            end
            S_SQRT: begin
                n_acc   = sq_v;
                n_mcand = sq_res;
                n_den   = r_den >> 2;
                n_cnt   = r_cnt - 7'd1;
                if (r_cnt == '0) begin
                    n_sd    = sq_res[STD_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.total     = r_snap.sum[39:0];
                    n_out.mean_q8   = r_mean;
                    n_out.std_q8    = r_sd;
                    n_out.count     = r_snap.count;
                    n_out.min_value = r_snap.min_value;
                    n_out.max_value = r_snap.max_value;
                    n_out.min_col   = r_snap.min_col;
                    n_out.min_row   = r_snap.min_row;
                    n_out.max_col   = r_snap.max_col;
                    n_out.max_row   = r_snap.max_row;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;  r_snap <= n_snap;  r_mag <= n_mag;
        r_acc <= n_acc;  r_mcand <= n_mcand;  r_div <= n_div;  r_mplier <= n_mplier;
        r_rem <= n_rem;  r_den <= n_den;  r_quo <= n_quo;
        r_mean <= n_mean;  r_sd <= n_sd;  r_out <= n_out;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("image finish while sequencer busy");
    a_var_no_borrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL_B) && r_mplier[0]) |-> alu_ge)
        else $error("spread of sums went negative");
    a_root_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> ((r_mcand & ALU_W'(r_den)) == '0))
        else $error("root trial bit overlaps partial root");
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_out_valid) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished result not loaded");
`endif

endmodule
`default_nettype wire

### src/thresholded_image_statistics.sv
// top level: configuration registers, pixel accumulator and finishing sequencer
`default_nettype none
// Pixels are taken one item per clock while the block is collecting an image.
// The item marked last hands the totals to a sequencer that runs the mean
// divide, the three products, the variance divide and the integer root on one
// shared 96-bit add/subtract unit, one bit per cycle, then loads the result register
// (an image with no included pixel goes straight to the load). The load waits while
// the previous result still waits unread; no pixel is taken until it is loaded.
// The result then waits in an output register while pixels of the next image
// are already taken.
module thresholded_image_statistics (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tis_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tis_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tis_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;
    logic       accept;
    logic       start;
    logic       idle;
    t_snap      snap;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lo_enable   <= 1'b0;
            r_cfg.hi_enable   <= 1'b0;
            r_cfg.thresh_low  <= 16'sh8000;
            r_cfg.thresh_high <= 16'sh7FFF;
            r_cfg.row_width   <= RW_W'(4096);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LO_EN:   r_cfg.lo_enable   <= pwdata[0];
                REG_HI_EN:   r_cfg.hi_enable   <= pwdata[0];
                REG_TH_LOW:  r_cfg.thresh_low  <= pwdata[PIX_W-1:0];
                REG_TH_HIGH: r_cfg.thresh_high <= pwdata[PIX_W-1:0];
                REG_ROW_W:   r_cfg.row_width   <= pwdata[RW_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_LO_EN:   prdata = 32'(r_cfg.lo_enable);
            REG_HI_EN:   prdata = 32'(r_cfg.hi_enable);
            REG_TH_LOW:  prdata = 32'($unsigned(r_cfg.thresh_low));
            REG_TH_HIGH: prdata = 32'($unsigned(r_cfg.thresh_high));
            REG_ROW_W:   prdata = 32'(r_cfg.row_width);
            default:     prdata = '0;
        endcase
    end

    // input handshake
    assign o_in_ready = idle;
    assign accept     = i_in_valid && idle;

    tis_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_pix    (i_in_data),
        .i_accept (accept),
        .o_start  (start),
        .o_snap   (snap)
    );

    tis_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_snap      (snap),
        .o_idle      (idle),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
